>>> rtl/integer_pixel_replicating_upscaler_macros.svh
// Assertion macros shared by the upscaler RTL.
// No dependencies; define ASSERT_OFF to compile every assertion away.
`ifndef INTEGER_PIXEL_REPLICATING_UPSCALER_MACROS_SVH
`define INTEGER_PIXEL_REPLICATING_UPSCALER_MACROS_SVH

`ifndef ASSERT_OFF

// Condition c must hold in the same cycle as a.
`define IPRU_ASSERT_SAME(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Condition c must hold in the cycle after a.
`define IPRU_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`else

`define IPRU_ASSERT_SAME(label, clk, rst, a, c)
`define IPRU_ASSERT_NEXT(label, clk, rst, a, c)

`endif

`endif

>>> rtl/ipru_pkg.sv
// Shared types and constants of the pixel replicating upscaler.
// No dependencies; used by the front, the back and the top level.
package ipru_pkg;

  // Result kinds carried in the low bits of the output tuser.
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_PAD   = 2'd2,
    KIND_DROP  = 2'd3
  } ipru_kind_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // One classified result travelling from the front to the back.
  typedef struct packed {
    logic       image_end;
    logic       row_end;
    ipru_kind_t kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } ipru_item_t;

endpackage

>>> rtl/integer_pixel_replicating_upscaler.sv
// Top level of the integer pixel replicating upscaler.
// Depends on ipru_pkg, ipru_front and ipru_back.
//
//  Channel | Direction | Handshake               | Contents
//  --------+-----------+-------------------------+----------------------------------
//  cfg     | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//  s_axis  | in        | s_axis_tvalid / tready  | tuser mode, tdata blue/green/red
//  m_axis  | out       | m_axis_tvalid / tready  | tuser kind/image_end, tdata, tlast
//
// One item is accepted per clock while the queue has room; every item gives
// exactly one result item. A result passes through the read stage (sequencer
// and line store read) and then the four-entry queue before it reaches m_axis.
// The input stalls only when the queue and the read stage together hold four
// items, so a stalled output takes four results before the input stops accepting.
// Reset is synchronous; it clears the counters, the queue and the
// configuration (scale, width and height all one). The line store holds
// undefined data until it is filled.

module integer_pixel_replicating_upscaler
  import ipru_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_SCALE = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // blue [7:0], green [15:8], red [23:16]
  input  logic        s_axis_tuser,   // mode: 0 source pixel, 1 output tick
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_blue [7:0], out_green [15:8], out_red [23:16]
  output logic [2:0]  m_axis_tuser,   // kind [1:0], image_end [2]
  output logic        m_axis_tlast    // row_end
);

  logic                push;
  ipru_item_t          push_item;
  logic [QUEUE_CW-1:0] queue_count;
  ipru_item_t          out_item;

  // Writes go straight into the registers, so they are always taken.
  assign cfg_ready = 1'b1;

  ipru_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_mode     (s_axis_tuser),
    .in_pixel    (s_axis_tdata),
    .queue_count (queue_count),
    .push        (push),
    .push_item   (push_item)
  );

  ipru_back u_back (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_item   (push_item),
    .queue_count (queue_count),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_item    (out_item)
  );

  assign m_axis_tdata = {out_item.red, out_item.green, out_item.blue};
  assign m_axis_tuser = {out_item.image_end, out_item.kind};
  assign m_axis_tlast = out_item.row_end;

endmodule

>>> rtl/ipru_front.sv
// Front of the upscaler: configuration registers, row sequencing and line store.
// Depends on ipru_pkg and the assertion macros header.
`include "integer_pixel_replicating_upscaler_macros.svh"

module ipru_front
  import ipru_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_SCALE = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [11:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  input  logic [23:0]         in_pixel,
  input  logic [QUEUE_CW-1:0] queue_count,
  output logic                push,
  output ipru_item_t          push_item
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int SW = $clog2(MAX_SCALE + 1);

  logic [4:0]  scale_factor;
  logic [11:0] source_width;
  logic [11:0] source_height;

  logic [CW-1:0] fill_count, fill_count_next;
  logic [CW-1:0] out_column, out_column_next;
  logic [SW-1:0] copy_count, copy_count_next;
  logic [SW-1:0] row_repeat, row_repeat_next;
  logic [1:0]    pad_count, pad_count_next;
  logic [11:0]   source_row, source_row_next;
  logic          emitting, emitting_next;

  logic [SW-1:0] eff_scale;
  logic [CW-1:0] eff_width;
  logic [11:0]   eff_height;
  logic [1:0]    row_bytes_mod, pad_len;

  logic [CW-1:0] fill_inc, column_inc;
  logic [SW-1:0] copy_inc, repeat_inc;
  logic [2:0]    pad_inc;
  logic [11:0]   row_inc;
  logic          closes;

  logic          accept;
  logic          store_we;
  ipru_kind_t    kind;
  logic          row_end, image_end;

  logic [23:0]   line_store [MAX_WIDTH];
  logic [23:0]   read_data;
  logic          s1_valid;
  ipru_kind_t    s1_kind;
  logic          s1_row_end, s1_image_end;

  // Configuration writes; an index past the register list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor  <= 5'd1;
      source_width  <= 12'd1;
      source_height <= 12'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCALE:  scale_factor  <= cfg_data[4:0];
        REG_WIDTH:  source_width  <= cfg_data;
        REG_HEIGHT: source_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Out-of-range settings are clamped into their working range.
  always_comb begin
    if (scale_factor == 5'd0) begin
      eff_scale = SW'(1);
    end else if (32'(scale_factor) > 32'(MAX_SCALE)) begin
      eff_scale = SW'(MAX_SCALE);
    end else begin
      eff_scale = SW'(scale_factor);
    end
    if (source_width == 12'd0) begin
      eff_width = CW'(1);
    end else if (32'(source_width) > 32'(MAX_WIDTH)) begin
      eff_width = CW'(MAX_WIDTH);
    end else begin
      eff_width = CW'(source_width);
    end
    eff_height = (source_height == 12'd0) ? 12'd1 : source_height;
  end

  // Padding depends only on the row byte count modulo four.
  assign row_bytes_mod = 2'(2'(eff_width) * 2'(eff_scale) * 2'd3);
  assign pad_len       = 2'(2'd0 - row_bytes_mod);

  assign fill_inc   = fill_count + CW'(1);
  assign column_inc = out_column + CW'(1);
  assign copy_inc   = copy_count + SW'(1);
  assign repeat_inc = row_repeat + SW'(1);
  assign pad_inc    = {1'b0, pad_count} + 3'd1;
  assign row_inc    = source_row + 12'd1;

  // The queue must keep room for the item held in the read stage.
  assign in_ready = ({1'b0, queue_count} + (QUEUE_CW + 1)'(s1_valid))
                    < (QUEUE_CW + 1)'(QUEUE_DEPTH);
  assign accept   = in_valid & in_ready;

  always_comb begin
    fill_count_next = fill_count;
    out_column_next = out_column;
    copy_count_next = copy_count;
    row_repeat_next = row_repeat;
    pad_count_next  = pad_count;
    source_row_next = source_row;
    emitting_next   = emitting;
    kind            = KIND_NONE;
    row_end         = 1'b0;
    image_end       = 1'b0;
    store_we        = 1'b0;
    closes          = 1'b0;

    if (!in_mode) begin
      if (emitting) begin
        kind = KIND_DROP;
      end else begin
        store_we        = 1'b1;
        fill_count_next = fill_inc;
        if (fill_inc >= eff_width) begin
          emitting_next   = 1'b1;
          out_column_next = '0;
          copy_count_next = '0;
          row_repeat_next = '0;
          pad_count_next  = '0;
        end
      end
    end else if (emitting) begin
      if (out_column < eff_width) begin
        kind = KIND_PIXEL;
        if (copy_inc >= eff_scale) begin
          copy_count_next = '0;
          out_column_next = column_inc;
          closes          = (column_inc >= eff_width) && (pad_len == 2'd0);
        end else begin
          copy_count_next = copy_inc;
        end
      end else begin
        kind           = KIND_PAD;
        pad_count_next = pad_inc[1:0];
        closes         = pad_inc >= {1'b0, pad_len};
      end

      if (closes) begin
        row_end         = 1'b1;
        out_column_next = '0;
        copy_count_next = '0;
        pad_count_next  = '0;
        if (repeat_inc >= eff_scale) begin
          row_repeat_next = '0;
          emitting_next   = 1'b0;
          fill_count_next = '0;
          if (row_inc >= eff_height) begin
            image_end       = 1'b1;
            source_row_next = '0;
          end else begin
            source_row_next = row_inc;
          end
        end else begin
          row_repeat_next = repeat_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      out_column <= '0;
      copy_count <= '0;
      row_repeat <= '0;
      pad_count  <= '0;
      source_row <= '0;
      emitting   <= 1'b0;
      s1_valid   <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        fill_count <= fill_count_next;
        out_column <= out_column_next;
        copy_count <= copy_count_next;
        row_repeat <= row_repeat_next;
        pad_count  <= pad_count_next;
        source_row <= source_row_next;
        emitting   <= emitting_next;
      end
    end
  end

  // Line store: one write port for filling, one registered read for replay.
  always_ff @(posedge clk) begin
    if (accept && store_we) begin
      line_store[fill_count[AW-1:0]] <= in_pixel;
    end
    if (accept) begin
      read_data <= line_store[out_column[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind      <= kind;
      s1_row_end   <= row_end;
      s1_image_end <= image_end;
    end
  end

  assign push                = s1_valid;
  assign push_item.kind      = s1_kind;
  assign push_item.row_end   = s1_row_end;
  assign push_item.image_end = s1_image_end;
  assign push_item.blue      = (s1_kind == KIND_PIXEL) ? read_data[7:0]   : 8'd0;
  assign push_item.green     = (s1_kind == KIND_PIXEL) ? read_data[15:8]  : 8'd0;
  assign push_item.red       = (s1_kind == KIND_PIXEL) ? read_data[23:16] : 8'd0;

  `IPRU_ASSERT_SAME(a_image_end_closes_row, clk, rst, s1_valid && s1_image_end, s1_row_end)
  `IPRU_ASSERT_SAME(a_image_end_refills, clk, rst, s1_valid && s1_image_end, !emitting)
  `IPRU_ASSERT_SAME(a_drop_only_emitting, clk, rst,
                    s1_valid && (s1_kind == KIND_DROP), emitting)

endmodule

>>> rtl/ipru_back.sv
// Back of the upscaler: result queue that drives the output stream.
// Depends on ipru_pkg and the assertion macros header.
`include "integer_pixel_replicating_upscaler_macros.svh"

module ipru_back
  import ipru_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ipru_item_t          push_item,
  output logic [QUEUE_CW-1:0] queue_count,
  output logic                out_valid,
  input  logic                out_ready,
  output ipru_item_t          out_item
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  ipru_item_t           entries [QUEUE_DEPTH];
  logic [PW-1:0]        wr_ptr, rd_ptr;
  logic [QUEUE_CW-1:0]  count;
  logic                 pop;

  assign out_valid   = count != '0;
  assign pop         = out_valid & out_ready;
  assign out_item    = entries[rd_ptr];
  assign queue_count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QUEUE_CW'(1);
        2'b01:   count <= count - QUEUE_CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  `IPRU_ASSERT_SAME(a_push_has_room, clk, rst, push, 32'(count) < QUEUE_DEPTH)
  `IPRU_ASSERT_NEXT(a_push_shows_valid, clk, rst, push, out_valid)

endmodule

>>> test/tb_integer_pixel_replicating_upscaler.sv
// Self-checking testbench for the integer pixel replicating upscaler.
// Depends on ipru_pkg and the integer_pixel_replicating_upscaler top level only.
// A scoreboard class predicts every result item and checks the output stream in order.
module tb_integer_pixel_replicating_upscaler;
  import ipru_pkg::*;

  localparam int unsigned LINE_DEPTH  = 2048;  // line store entries, also the width limit
  localparam int unsigned SCALE_LIMIT = 16;
  localparam int unsigned RUN_ITEMS   = 480;   // directed plus random items before the extremes
  localparam int unsigned HOLD_CYCLES = 300;   // one long output stall
  localparam int unsigned QUIET_LIMIT = 1000;  // cycles without any handshake before giving up
  localparam int unsigned MAX_PRINTS  = 200;

  // Predicts the upscaler item by item and holds the results still to come.
  class upscale_scoreboard;
    logic [23:0] line_pixels [LINE_DEPTH];
    logic [11:0] fill_count;
    logic [11:0] out_column;
    logic [11:0] source_row;
    logic [4:0]  copy_count;
    logic [4:0]  row_repeat;
    logic [1:0]  pad_count;
    bit          emitting;
    logic [4:0]  scale_reg;
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    int unsigned filled_hw;   // store entries written at least once since reset
    int unsigned rows_done;   // source rows fully replayed
    int unsigned errors;
    ipru_item_t  expected_q[$];

    function new();
      fill_count = '0;
      out_column = '0;
      source_row = '0;
      copy_count = '0;
      row_repeat = '0;
      pad_count  = '0;
      emitting   = 1'b0;
      scale_reg  = 5'd1;
      width_reg  = 12'd1;
      height_reg = 12'd1;
      filled_hw  = 0;
      rows_done  = 0;
      errors     = 0;
    endfunction

    function int unsigned eff_scale();
      int unsigned s;
      s = scale_reg;
      if (s == 0) s = 1;
      if (s > SCALE_LIMIT) s = SCALE_LIMIT;
      return s;
    endfunction

    function int unsigned eff_width();
      int unsigned w;
      w = width_reg;
      if (w == 0) w = 1;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      return w;
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void set_reg(logic [1:0] idx, logic [11:0] val);
      case (idx)
        REG_SCALE:  scale_reg  = val[4:0];
        REG_WIDTH:  width_reg  = val;
        REG_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    // One accepted item: update the sequencer copy and queue its result.
    function void note_input(bit tick, logic [23:0] pix);
      int unsigned s, w, h, p;
      bit          closes;
      ipru_item_t  e;
      s = eff_scale();
      w = eff_width();
      h = eff_height();
      e = '0;
      closes = 1'b0;
      if (!tick) begin
        if (emitting) begin
          e.kind = KIND_DROP;
        end else begin
          if (fill_count < LINE_DEPTH) line_pixels[fill_count] = pix;
          fill_count++;
          if (fill_count > filled_hw) filled_hw = fill_count;
          if (fill_count >= w) begin
            emitting   = 1'b1;
            out_column = '0;
            copy_count = '0;
            row_repeat = '0;
            pad_count  = '0;
          end
        end
      end else if (emitting) begin
        p = (4 - (w * s * 3) % 4) % 4;
        if (out_column < w) begin
          e.kind = KIND_PIXEL;
          {e.red, e.green, e.blue} = line_pixels[out_column];
          copy_count++;
          if (copy_count >= s) begin
            copy_count = '0;
            out_column++;
            if (out_column >= w && p == 0) closes = 1'b1;
          end
        end else begin
          // Past the last column, either normal padding or a width that shrank mid-row.
          e.kind = KIND_PAD;
          pad_count++;
          if (pad_count >= p) closes = 1'b1;
        end
        if (closes) begin
          e.row_end  = 1'b1;
          out_column = '0;
          copy_count = '0;
          pad_count  = '0;
          row_repeat++;
          if (row_repeat >= s) begin
            row_repeat = '0;
            emitting   = 1'b0;
            fill_count = '0;
            rows_done++;
            source_row++;
            if (source_row >= h) begin
              e.image_end = 1'b1;
              source_row  = '0;
            end
          end
        end
      end
      expected_q.push_back(e);
    endfunction

    // One accepted result: compare every field with the oldest prediction.
    // Printed as kind, blue/green/red, then row_end and image_end.
    function void check_result(logic [23:0] data, logic [2:0] user, logic last);
      ipru_item_t got, want;
      got.blue      = data[7:0];
      got.green     = data[15:8];
      got.red       = data[23:16];
      got.kind      = ipru_kind_t'(user[1:0]);
      got.image_end = user[2];
      got.row_end   = last;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_PRINTS)
          $display("%0t: expected no result, actual %0d %h/%h/%h %b%b",
                   $time, got.kind, got.blue, got.green, got.red, got.row_end,
                   got.image_end);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_PRINTS)
          $display("%0t: expected %0d %h/%h/%h %b%b, actual %0d %h/%h/%h %b%b",
                   $time, want.kind, want.blue, want.green, want.red, want.row_end,
                   want.image_end, got.kind, got.blue, got.green, got.red, got.row_end,
                   got.image_end);
      end
    endfunction
  endclass

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index     = REG_SCALE;
  logic [11:0] cfg_data      = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // blue [7:0], green [15:8], red [23:16]
  logic        s_axis_tuser  = 1'b0; // mode: 0 source pixel, 1 output tick
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // out_blue [7:0], out_green [15:8], out_red [23:16]
  logic [2:0]  m_axis_tuser;         // kind [1:0], image_end [2]
  logic        m_axis_tlast;         // row_end

  upscale_scoreboard sb = new();

  int unsigned items_sent         = 0;
  int unsigned sender_idle_pct    = 36;
  int unsigned receiver_idle_pct  = 78;
  bit          hold_req           = 1'b0;
  bit          hold_done          = 1'b0;
  int unsigned hold_left          = 0;
  int unsigned quiet_cycles       = 0;

  integer_pixel_replicating_upscaler uut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // Output side: check every accepted result, then pick the next ready level.
  // A requested hold keeps ready low for a long stretch so the input backs up.
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Any handshake counts as progress; a long silence means the block hung.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("integer_pixel_replicating_upscaler: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Idling goes through three stretches: receiver-heavy gaps, sender-heavy gaps, none.
  // The long output hold is requested once, at the start of the stretch without gaps.
  function automatic void update_idling();
    if (items_sent < 260) begin
      sender_idle_pct   = 36;
      receiver_idle_pct = 78;
    end else if (items_sent < 520) begin
      sender_idle_pct   = 78;
      receiver_idle_pct = 36;
    end else begin
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      if (!hold_done) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
    end
  endfunction

  function automatic logic [23:0] random_pixel();
    case ($urandom_range(7))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // Offers one item, with random gaps first, and records it once accepted.
  task automatic send_item(bit tick, logic [23:0] pix);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= tick;
    s_axis_tdata  <= pix;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(tick, pix);
    items_sent++;
    update_idling();
  endtask

  // Mostly the item the block is waiting for; now and then the wrong kind.
  task automatic send_next();
    bit tick;
    tick = sb.emitting;
    if ($urandom_range(99) < 6) tick = !tick;
    send_item(tick, random_pixel());
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Valid is lowered only after the last write of a burst, so it never toggles within a step.
  task automatic write_reg(logic [1:0] idx, logic [11:0] val, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(logic [11:0] scale, logic [11:0] width, logic [11:0] height);
    drain();
    write_reg(REG_SCALE, scale, 1'b0);
    write_reg(REG_WIDTH, width, 1'b0);
    write_reg(REG_HEIGHT, height, 1'b1);
  endtask

  // A register change in the middle of an output row. The width is never raised past
  // the entries already written, so no unwritten store entry is ever read back.
  task automatic change_mid_row();
    int unsigned cap;
    drain();
    cap = (sb.filled_hw < 12) ? sb.filled_hw : 12;
    case ($urandom_range(2))
      0:       write_reg(REG_SCALE, 12'($urandom_range(1, 4)), 1'b1);
      1:       write_reg(REG_WIDTH, 12'($urandom_range(1, cap)), 1'b1);
      default: write_reg(REG_HEIGHT, 12'($urandom_range(0, 3)), 1'b1);
    endcase
  endtask

  // One setting: an optional partly filled row left over from before, then the new
  // registers, then items until the requested number of source rows is replayed.
  task automatic run_phase(logic [11:0] scale, logic [11:0] width, logic [11:0] height,
                           int unsigned rows, bit allow_mid);
    int unsigned goal;
    int unsigned leftover;
    bit          mid;
    leftover = allow_mid ? $urandom_range(0, 3) : 0;
    while (leftover != 0 && !sb.emitting && sb.fill_count + 1 < sb.eff_width()) begin
      send_item(1'b0, random_pixel());
      leftover--;
    end
    program_regs(scale, width, height);
    mid  = allow_mid && ($urandom_range(2) == 0);
    goal = sb.rows_done + rows;
    while (sb.rows_done < goal) begin
      if (mid && sb.emitting && sb.out_column != 0) begin
        mid = 1'b0;
        change_mid_row();
      end
      send_next();
    end
  endtask

  // Small sizes for the bulk; a large scale only with the narrowest rows.
  task automatic random_phase();
    logic [11:0] scale, width, height;
    bit          big;
    scale  = ($urandom_range(7) == 0) ? 12'($urandom_range(0, 4095)) :
                                        12'($urandom_range(1, 3));
    big    = (scale[4:0] > 4);
    width  = big ? 12'($urandom_range(0, 1)) : 12'($urandom_range(0, 8));
    height = ($urandom_range(7) == 0) ? 12'($urandom_range(0, 4095)) :
                                        12'($urandom_range(0, 3));
    run_phase(scale, width, height, big ? 1 : $urandom_range(1, 3), 1'b1);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A tick before any row is held gives an empty result.
    send_item(1'b1, 24'h123456);
    // Zero in every register is taken as one: a single pixel, one padding byte.
    program_regs(12'd0, 12'd0, 12'd0);
    send_item(1'b0, 24'hFFFFFF);
    send_item(1'b0, 24'h000000);  // arrives while emitting, dropped
    send_item(1'b1, random_pixel());
    send_item(1'b1, random_pixel());
    // Doubling a three-pixel row: each row is six pixels plus two padding bytes.
    program_regs(12'd2, 12'd3, 12'd2);
    send_item(1'b0, 24'h000000);
    send_item(1'b0, 24'hA5C35A);
    send_item(1'b0, 24'hFFFFFF);
    repeat (16) send_item(1'b1, random_pixel());

    // Scale above the limit saturates; height zero ends the image after each row.
    run_phase(12'd31, 12'd1, 12'd0, 1, 1'b0);
    run_phase(12'd0, 12'd0, 12'd3, 4, 1'b0);
    while (items_sent < RUN_ITEMS) random_phase();
    // The largest exact scale with a height far above the rows sent.
    run_phase(12'd16, 12'd1, 12'd4095, 1, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("integer_pixel_replicating_upscaler: match");
    end else begin
      $display("integer_pixel_replicating_upscaler: mismatch");
    end
    $finish;
  end

endmodule
